### design/dec_pkg.sv
// Shared types, constants and tables of the density-effect correction block.
package dec_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_FRAC  = FRAC_BITS + 8;
    localparam int LOG_STEPS  = 30;
    localparam int EXP_TERMS  = 12;

    // 2 ln10 and 2 log2(10) in Q28, ln2 in Q30
    localparam logic [30:0] K_2LN10    = 31'd1236190959;
    localparam logic [30:0] K_2LOG2_10 = 31'd1783446566;
    localparam logic [29:0] K_LN2      = 30'd744261118;

    // lower clamp of x - X0: -64.0 in Q16.16
    localparam logic signed [32:0] T_MIN = -33'sd4194304;

    typedef enum logic [2:0] {
        CFG_C_BAR       = 3'd0,
        CFG_X_LOWER     = 3'd1,
        CFG_X_UPPER     = 3'd2,
        CFG_COEFF_A     = 3'd3,
        CFG_EXPONENT_M  = 3'd4,
        CFG_DELTA_LOWER = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REGION_BELOW = 2'd0,
        REGION_MID   = 2'd1,
        REGION_ABOVE = 2'd2
    } region_t;

    // exact floor(v/k) for v < 2^30: (v * RECIP[k]) >> RSHIFT[k]
    localparam logic [30:0] RECIP [1:12] = '{
        31'd1073741824, 31'd1073741824, 31'd1431655766, 31'd1073741824,
        31'd1717986919, 31'd1431655766, 31'd1227133514, 31'd1073741824,
        31'd1908874354, 31'd1717986919, 31'd1561806290, 31'd1431655766
    };
    localparam logic [5:0] RSHIFT [1:12] = '{
        6'd30, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33,
        6'd33, 6'd33, 6'd34, 6'd34, 6'd34, 6'd34
    };

    typedef struct packed {
        region_t            region;
        logic signed [34:0] lin;
        logic signed [23:0] t;
        logic signed [6:0]  ip;
    } log_side_t;

    typedef struct packed {
        region_t            region;
        logic signed [34:0] lin;
        logic signed [11:0] n;
    } exp_side_t;

endpackage

### design/density_effect_correction_core.sv
// Density-effect correction delta(x): pipelined log2, power and exp datapath.
//
// Input channel (in_valid/in_ready, x_value) takes one x = log10(beta*gamma)
// in signed Q16.16 per transaction. Output channel (out_valid/out_ready)
// returns delta (Q16.16, saturated), region and the saturated flag, one
// result per input, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 C, 1 X0, 2 X1, 3 a, 4 m, 5 delta0; other indices
// are ignored. Write only while no transaction is in flight.
// Depth: 64 register stages. Throughput: one transaction per cycle while the
// output is not stalled. The depth is set by the 30 squaring stages of the
// log2 unit and the 12 two-stage terms of the exp2 series.
// Stall: the whole pipeline holds while a result waits and out_ready is low;
// in_ready follows (low only when the output register is full and stalled).
// Reset: all valid bits clear, configuration registers take their defaults.
module density_effect_correction_core
    import dec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  x_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  delta,
    output logic [1:0]          region,
    output logic                saturated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    // configuration
    logic signed [31:0] c_bar_reg, x_lower_reg, x_upper_reg, coeff_a_reg;
    logic [20:0]        exponent_m_reg;
    logic [30:0]        delta_lower_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_bar_reg       <= 32'sd0;
            x_lower_reg     <= 32'sd13107;
            x_upper_reg     <= 32'sd131072;
            coeff_a_reg     <= 32'sd0;
            exponent_m_reg  <= 21'd196608;
            delta_lower_reg <= 31'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_C_BAR:       c_bar_reg       <= cfg_data;
                CFG_X_LOWER:     x_lower_reg     <= cfg_data;
                CFG_X_UPPER:     x_upper_reg     <= cfg_data;
                CFG_COEFF_A:     coeff_a_reg     <= cfg_data;
                CFG_EXPONENT_M:  exponent_m_reg  <= cfg_data[20:0];
                CFG_DELTA_LOWER: delta_lower_reg <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;
    assign adv      = ~out_valid_reg | out_ready;
    assign in_ready = adv;

    // stage 0: capture and classify
    logic               s0_valid_reg;
    logic signed [31:0] s0_x_reg;
    region_t            s0_region_reg, s0_region_next;

    always_comb
    begin
        priority if (x_value < x_lower_reg)
            s0_region_next = REGION_BELOW;
        else if (x_value >= x_upper_reg)
            s0_region_next = REGION_ABOVE;
        else
            s0_region_next = REGION_MID;
    end

    // stage 1: linear product, distances
    logic               s1_valid_reg;
    region_t            s1_region_reg;
    logic signed [63:0] s1_prod_reg, s1_prod_next;
    logic [32:0]        s1_d_reg, s1_d_next;
    logic signed [23:0] s1_t_reg, s1_t_next;
    logic signed [32:0] t_diff, t_clamp;

    assign s1_prod_next = s0_x_reg * signed'({1'b0, K_2LN10});
    assign s1_d_next    = {x_upper_reg[31], x_upper_reg} - {s0_x_reg[31], s0_x_reg};
    assign t_diff       = {s0_x_reg[31], s0_x_reg} - {x_lower_reg[31], x_lower_reg};
    assign t_clamp      = (t_diff < T_MIN) ? T_MIN : t_diff;
    assign s1_t_next    = t_clamp[23:0];

    // stage 2: round linear term, leading one
    logic               s2_valid_reg;
    region_t            s2_region_reg;
    logic signed [34:0] s2_lin_reg, s2_lin_next;
    logic [32:0]        s2_d_reg;
    logic signed [23:0] s2_t_reg;
    logic [5:0]         s2_p_reg, s2_p_next;
    logic signed [63:0] lin_sum;

    assign lin_sum     = s1_prod_reg + (s1_prod_reg[63] ? 64'sd134217727 : 64'sd134217728);
    assign s2_lin_next = lin_sum[62:28];

    always_comb
    begin
        s2_p_next = 6'd0;
        for (int i = 0; i < 33; i++)
        begin
            if (s1_d_reg[i])
                s2_p_next = 6'(i);
        end
    end

    // stage 3: normalise mantissa into log stage 0
    logic       lv_reg [0:LOG_STEPS];
    logic [30:0] lz_reg [0:LOG_STEPS];
    logic [29:0] lf_reg [0:LOG_STEPS];
    log_side_t  ls_reg [0:LOG_STEPS];
    logic [63:0] d_wide;
    logic [30:0] z_norm;

    assign d_wide = {31'd0, s2_d_reg};

    always_comb
    begin
        if (s2_p_reg > 6'd30)
            z_norm = 31'(d_wide >> (s2_p_reg - 6'd30));
        else
            z_norm = 31'(d_wide << (6'd30 - s2_p_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            lv_reg[0]    <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            lv_reg[0]    <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_x_reg         <= x_value;
            s0_region_reg    <= s0_region_next;
            s1_region_reg    <= s0_region_reg;
            s1_prod_reg      <= s1_prod_next;
            s1_d_reg         <= s1_d_next;
            s1_t_reg         <= s1_t_next;
            s2_region_reg    <= s1_region_reg;
            s2_lin_reg       <= s2_lin_next;
            s2_d_reg         <= s1_d_reg;
            s2_t_reg         <= s1_t_reg;
            s2_p_reg         <= s2_p_next;
            lz_reg[0]        <= z_norm;
            lf_reg[0]        <= 30'd0;
            ls_reg[0].region <= s2_region_reg;
            ls_reg[0].lin    <= s2_lin_reg;
            ls_reg[0].t      <= s2_t_reg;
            ls_reg[0].ip     <= 7'(s2_p_reg) - 7'sd16;
        end
    end

    // log2 fraction: one squaring per stage
    for (genvar j = 1; j <= LOG_STEPS; j++)
    begin : g_log
        logic [61:0] sq;
        assign sq = 62'(lz_reg[j-1]) * 62'(lz_reg[j-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lv_reg[j] <= 1'b0;
            else if (adv)
                lv_reg[j] <= lv_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ls_reg[j] <= ls_reg[j-1];
                if (sq[61])
                begin
                    lz_reg[j] <= sq[61:31];
                    lf_reg[j] <= lf_reg[j-1] | (30'd1 << (LOG_STEPS - j));
                end
                else
                begin
                    lz_reg[j] <= sq[60:30];
                    lf_reg[j] <= lf_reg[j-1];
                end
            end
        end
    end

    // E1: exponent products
    logic               e1_valid_reg;
    log_side_t          e1_side_reg;
    logic [50:0]        e1_pm1_reg, e1_pm1_next;
    logic signed [28:0] e1_pm2_reg, e1_pm2_next;
    logic signed [55:0] e1_pl_reg, e1_pl_next;

    assign e1_pm1_next = 51'(exponent_m_reg) * 51'(lf_reg[LOG_STEPS]);
    assign e1_pm2_next = ls_reg[LOG_STEPS].ip * signed'({1'b0, exponent_m_reg});
    assign e1_pl_next  = ls_reg[LOG_STEPS].t * signed'({1'b0, K_2LOG2_10});

    // E2: rounded exponent, selected by region
    logic               e2_valid_reg;
    exp_side_t          e2_side_reg;
    logic signed [41:0] e2_e_reg, e2_e_next;
    logic signed [59:0] v_mid, v_mid_r;
    logic signed [55:0] v_low_r;

    assign v_mid   = (60'(e1_pm2_reg) <<< 30) + signed'(60'(e1_pm1_reg));
    assign v_mid_r = v_mid + (v_mid[59] ? 60'sd32767 : 60'sd32768);
    assign v_low_r = e1_pl_reg + (e1_pl_reg[55] ? 56'sd8191 : 56'sd8192);
    assign e2_e_next = (e1_side_reg.region == REGION_BELOW) ? v_low_r[55:14] : v_mid_r[57:16];

    // Y stage and exp2 series
    logic        eb_valid_reg [0:EXP_TERMS];
    exp_side_t   eb_side_reg  [0:EXP_TERMS];
    logic [29:0] eb_y_reg     [0:EXP_TERMS];
    logic [30:0] eb_term_reg  [0:EXP_TERMS];
    logic [31:0] eb_sum_reg   [0:EXP_TERMS];
    logic [59:0] y_prod;

    assign y_prod = 60'(e2_e_reg[29:0]) * 60'(K_LN2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg    <= 1'b0;
            e2_valid_reg    <= 1'b0;
            eb_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            e1_valid_reg    <= lv_reg[LOG_STEPS];
            e2_valid_reg    <= e1_valid_reg;
            eb_valid_reg[0] <= e2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_side_reg           <= ls_reg[LOG_STEPS];
            e1_pm1_reg            <= e1_pm1_next;
            e1_pm2_reg            <= e1_pm2_next;
            e1_pl_reg             <= e1_pl_next;
            e2_side_reg.region    <= e1_side_reg.region;
            e2_side_reg.lin       <= e1_side_reg.lin;
            e2_side_reg.n         <= 12'sd0;
            e2_e_reg              <= e2_e_next;
            eb_side_reg[0].region <= e2_side_reg.region;
            eb_side_reg[0].lin    <= e2_side_reg.lin;
            eb_side_reg[0].n      <= e2_e_reg[41:30];
            eb_y_reg[0]           <= y_prod[59:30];
            eb_term_reg[0]        <= 31'h4000_0000;
            eb_sum_reg[0]         <= 32'h4000_0000;
        end
    end

    logic        ea_valid_reg [1:EXP_TERMS];
    exp_side_t   ea_side_reg  [1:EXP_TERMS];
    logic [29:0] ea_y_reg     [1:EXP_TERMS];
    logic [30:0] ea_p_reg     [1:EXP_TERMS];
    logic [31:0] ea_sum_reg   [1:EXP_TERMS];

    for (genvar k = 1; k <= EXP_TERMS; k++)
    begin : g_exp
        logic [60:0] tp;
        logic [61:0] qp;
        logic [30:0] q;
        assign tp = 61'(eb_term_reg[k-1]) * 61'(eb_y_reg[k-1]);
        assign qp = 62'(ea_p_reg[k]) * 62'(RECIP[k]);
        assign q  = 31'(qp >> RSHIFT[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ea_valid_reg[k] <= 1'b0;
                eb_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                ea_valid_reg[k] <= eb_valid_reg[k-1];
                eb_valid_reg[k] <= ea_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ea_side_reg[k] <= eb_side_reg[k-1];
                ea_y_reg[k]    <= eb_y_reg[k-1];
                ea_p_reg[k]    <= tp[60:30];
                ea_sum_reg[k]  <= eb_sum_reg[k-1];
                eb_side_reg[k] <= ea_side_reg[k];
                eb_y_reg[k]    <= ea_y_reg[k];
                eb_term_reg[k] <= q;
                eb_sum_reg[k]  <= ea_sum_reg[k] + 32'(q);
            end
        end
    end

    // M: scale factor times mantissa
    logic               m_valid_reg;
    region_t            m_region_reg;
    logic signed [34:0] m_lin_reg;
    logic [63:0]        m_mag_reg, m_mag_next;
    logic signed [12:0] m_s_reg, m_s_next;
    logic [31:0]        a_mag, mul_sel;
    exp_side_t          m_in;

    assign m_in       = eb_side_reg[EXP_TERMS];
    assign a_mag      = coeff_a_reg[31] ? (~coeff_a_reg + 32'd1) : coeff_a_reg;
    assign mul_sel    = (m_in.region == REGION_BELOW) ? {1'b0, delta_lower_reg} : a_mag;
    assign m_mag_next = 64'(mul_sel) * 64'(eb_sum_reg[EXP_TERMS]);
    assign m_s_next   = 13'(m_in.n) - ((m_in.region == REGION_BELOW) ? 13'sd30 : 13'sd38);

    // SC: shift by 2^s with rounding; anything at or above 2^50 saturates later
    logic               sc_valid_reg;
    region_t            sc_region_reg;
    logic signed [34:0] sc_lin_reg;
    logic [50:0]        sc_pm_reg, sc_pm_next;
    logic [12:0]        r_amt;
    logic [63:0]        r_sh, r_val;
    logic [112:0]       l_wide;

    assign r_amt  = 13'(-m_s_reg);
    assign r_sh   = m_mag_reg >> (r_amt[5:0] - 6'd1);
    assign r_val  = (r_sh >> 1) + 64'(r_sh[0]);
    assign l_wide = 113'(m_mag_reg) << m_s_reg[5:0];

    always_comb
    begin
        if (m_mag_reg == 64'd0)
            sc_pm_next = 51'd0;
        else if (m_s_reg < 13'sd0)
        begin
            if (r_amt >= 13'd64)
                sc_pm_next = 51'd0;
            else if (r_val >= (64'd1 << 50))
                sc_pm_next = 51'd1 << 50;
            else
                sc_pm_next = r_val[50:0];
        end
        else if (m_s_reg >= 13'sd50 || l_wide >= (113'd1 << 50))
            sc_pm_next = 51'd1 << 50;
        else
            sc_pm_next = l_wide[50:0];
    end

    // OUT: combine and saturate
    localparam logic signed [53:0] SAT_HI = (54'sd1 <<< (DATA_WIDTH - 1)) - 54'sd1;
    localparam logic signed [53:0] SAT_LO = -(54'sd1 <<< (DATA_WIDTH - 1));

    logic signed [35:0] base;
    logic signed [53:0] pm_s, total;
    logic signed [31:0] delta_reg, delta_next;
    logic [1:0]         region_reg;
    logic               sat_reg, sat_next;

    assign base = 36'(sc_lin_reg) - 36'(c_bar_reg);
    assign pm_s = signed'(54'(sc_pm_reg));

    always_comb
    begin
        unique case (sc_region_reg)
            REGION_BELOW: total = pm_s;
            REGION_ABOVE: total = 54'(base);
            default:      total = coeff_a_reg[31] ? 54'(base) - pm_s : 54'(base) + pm_s;
        endcase
        priority if (total > SAT_HI)
        begin
            delta_next = 32'(SAT_HI);
            sat_next   = 1'b1;
        end
        else if (total < SAT_LO)
        begin
            delta_next = 32'(SAT_LO);
            sat_next   = 1'b1;
        end
        else
        begin
            delta_next = total[31:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            sc_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg   <= eb_valid_reg[EXP_TERMS];
            sc_valid_reg  <= m_valid_reg;
            out_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_region_reg  <= m_in.region;
            m_lin_reg     <= m_in.lin;
            m_mag_reg     <= m_mag_next;
            m_s_reg       <= m_s_next;
            sc_region_reg <= m_region_reg;
            sc_lin_reg    <= m_lin_reg;
            sc_pm_reg     <= sc_pm_next;
            delta_reg     <= delta_next;
            region_reg    <= sc_region_reg;
            sat_reg       <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign delta     = delta_reg;
    assign region    = region_reg;
    assign saturated = sat_reg;

endmodule

### design/dec_checker.sv
// Port-level checker of the density-effect correction core, with its bind.
module dec_checker
    import dec_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] delta,
    input logic [1:0]         region,
    input logic               saturated
);

    localparam logic signed [31:0] D_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] D_MIN = 32'sh8000_0000;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(delta) && $stable(region) && $stable(saturated))
        else $error("stalled result changed");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> delta == D_MAX || delta == D_MIN)
        else $error("saturated result not at a limit");

    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> region != 2'd3)
        else $error("bad region code");

endmodule

bind density_effect_correction_core dec_checker u_dec_checker (.*);

### tb/tb_top.sv
// Self-checking testbench of density_effect_correction_core: directed and random streams against a delta predictor.
`timescale 1ns / 100ps

module tb_top;
    import dec_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int         PIPE_WAIT  = 80;
    localparam longint     ONE30      = 64'sd1073741824;
    localparam int         N_DIRECTED = 11;

    // field extremes and region edges with reset settings
    localparam logic [31:0] DIRECTED_X [N_DIRECTED] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd13107,
        32'd13106, 32'd131072, 32'd131071, 32'd65536, 32'hAAAA_AAAA,
        32'h5555_5555
    };

    typedef struct {
        logic signed [31:0] delta;
        region_t            region;
        logic               sat;
    } dec_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] x_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] delta;
    logic [1:0]         region;
    logic               saturated;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // predictor copy of the configuration
    logic [31:0] p_c_bar, p_x0, p_x1, p_coeff_a;
    logic [20:0] p_exp_m;
    logic [30:0] p_delta0;

    logic [31:0]  x_pending_q [$];
    dec_result_t  delta_exp_q [$];
    int           mismatches;
    int           in_gap_left;
    int           out_gap_left;
    bit           no_idle;
    bit           finished;

    density_effect_correction_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_value   (x_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .delta     (delta),
        .region    (region),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned mag_of(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned round_shr(longint unsigned m, longint s);
        if (s <= 0)
            return m;
        if (s >= 64)
            return 0;
        return (m >> s) + ((m >> (s - 1)) & 64'd1);
    endfunction

    function automatic longint round_shr_signed(longint v, longint s);
        longint unsigned m;
        m = round_shr(mag_of(v), s);
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned scale_clamped(longint unsigned m, longint s);
        if (m == 0)
            return 0;
        if (s < 0)
            return round_shr(m, -s);
        if (s >= 50 || (m >> (50 - s)) != 0)
            return 64'd1 << 50;
        return m << s;
    endfunction

    // log2 of a positive Q16.16 value, Q30 result
    function automatic longint log2_fix(longint unsigned d);
        int               p;
        longint unsigned  z;
        longint unsigned  frac;
        p = 63;
        frac = 0;
        while (p > 0 && d[p] == 1'b0)
            p--;
        z = (p > 30) ? d >> (p - 30) : d << (30 - p);
        for (int i = 29; i >= 0; i--)
        begin
            z = (z * z) >> 30;
            if (z >= (64'd2 << 30))
            begin
                z = z >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        return (longint'(p) - FRAC_BITS) * ONE30 + longint'(frac);
    endfunction

    // 2^e with e in Q30: Q30 mantissa, integer exponent in n
    function automatic longint unsigned exp2_fix(longint e, output longint n);
        longint unsigned f, y, term, sum;
        if (e >= 0)
            n = e / ONE30;
        else
            n = -longint'((mag_of(e) + 64'd1073741823) >> 30);
        f = (longint'(e) - n * ONE30) & 64'h3FFF_FFFF;
        y = (f * longint'(K_LN2)) >> 30;
        term = 64'd1 << 30;
        sum = term;
        for (int k = 1; k <= EXP_TERMS; k++)
        begin
            term = ((term * y) >> 30) / k;
            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic dec_result_t predict_delta(logic [31:0] x_raw);
        dec_result_t     r;
        longint          x, x0, x1, c, a, t, e, n, lin, total;
        longint unsigned mant, pm;
        x  = longint'($signed(x_raw));
        x0 = longint'($signed(p_x0));
        x1 = longint'($signed(p_x1));
        c  = longint'($signed(p_c_bar));
        a  = longint'($signed(p_coeff_a));
        r.sat = 1'b0;
        if (x < x0)
        begin
            r.region = REGION_BELOW;
            total = 0;
            if (p_delta0 != 0)
            begin
                t = x - x0;
                if (t < -(64 * 65536))
                    t = -(64 * 65536);
                e = round_shr_signed(t * longint'(K_2LOG2_10), FRAC_BITS + 28 - 30);
                mant = exp2_fix(e, n);
                total = longint'(scale_clamped(longint'(p_delta0) * mant, n - 30));
            end
        end
        else
        begin
            lin = round_shr_signed(x * longint'(K_2LN10), 28);
            if (x >= x1)
            begin
                r.region = REGION_ABOVE;
                total = lin - c;
            end
            else
            begin
                r.region = REGION_MID;
                e = round_shr_signed(longint'(p_exp_m) * log2_fix(x1 - x), FRAC_BITS);
                mant = exp2_fix(e, n);
                pm = scale_clamped(mag_of(a) * mant, n + FRAC_BITS - COEF_FRAC - 30);
                total = lin - c + ((a < 0) ? -longint'(pm) : longint'(pm));
            end
        end
        if (total > 64'sd2147483647)
        begin
            total = 64'sd2147483647;
            r.sat = 1'b1;
        end
        if (total < -64'sd2147483648)
        begin
            total = -64'sd2147483648;
            r.sat = 1'b1;
        end
        r.delta = total[31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x_value <= '0;
            in_gap_left = 0;
        end
        else
        begin
            nxt_valid = in_valid;
            if (in_valid && in_ready)
            begin
                delta_exp_q.push_back(predict_delta(x_value));
                void'(x_pending_q.pop_front());
                in_gap_left = pick_gap();
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (in_gap_left > 0)
                    in_gap_left--;
                else if (x_pending_q.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    x_value <= x_pending_q[0];
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // output monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        dec_result_t ex;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (delta_exp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: delta=%0d region=%0d sat=%0b",
                                 delta, region, saturated);
                end
                else
                begin
                    ex = delta_exp_q.pop_front();
                    if (delta !== ex.delta || region !== ex.region || saturated !== ex.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp delta=%0d region=%0d sat=%0b, got %0d %0d %0b",
                                     ex.delta, ex.region, ex.sat, delta, region, saturated);
                    end
                end
                out_gap_left = pick_gap();
            end
            if (out_gap_left > 0)
            begin
                out_gap_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_C_BAR:       p_c_bar = val;
            CFG_X_LOWER:     p_x0 = val;
            CFG_X_UPPER:     p_x1 = val;
            CFG_COEFF_A:     p_coeff_a = val;
            CFG_EXPONENT_M:  p_exp_m = val[20:0];
            CFG_DELTA_LOWER: p_delta0 = val[30:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (x_pending_q.size() != 0 || delta_exp_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    task automatic load_cfg(longint c, longint x0, longint x1, longint a, longint m,
                            longint d0);
        wait_idle();
        write_reg(CFG_C_BAR, c[31:0]);
        write_reg(CFG_X_LOWER, x0[31:0]);
        write_reg(CFG_X_UPPER, x1[31:0]);
        write_reg(CFG_COEFF_A, a[31:0]);
        write_reg(CFG_EXPONENT_M, m[31:0]);
        write_reg(CFG_DELTA_LOWER, d0[31:0]);
        // unknown index must leave every register untouched
        write_reg(CFG_UNUSED, $urandom);
    endtask

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic [31:0] pick_x();
        longint x0, x1, span;
        x0 = longint'($signed(p_x0));
        x1 = longint'($signed(p_x1));
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4:
            begin
                if (x1 <= x0)
                    return $urandom;
                span = x1 - x0;
                return clip32(x0 + longint'({$urandom, $urandom} % longint'(span)));
            end
            5, 6:    return clip32(x0 - $urandom_range(1, 70 << 16));
            7:       return clip32(x0 + $signed($urandom_range(0, 16)) - 8);
            8:       return clip32(x1 + $signed($urandom_range(0, 16)) - 8);
            default: return clip32($signed($urandom_range(0, 10 << 16)) - (5 << 16));
        endcase
    endfunction

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            x_pending_q.push_back(pick_x());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        no_idle = 1'b0;
        finished = 1'b0;
        p_c_bar = 32'd0;
        p_x0 = 32'd13107;
        p_x1 = 32'd131072;
        p_coeff_a = 32'd0;
        p_exp_m = 21'd196608;
        p_delta0 = 31'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and region edges with reset settings
        for (int i = 0; i < N_DIRECTED; i++)
            x_pending_q.push_back(DIRECTED_X[i]);

        // conductor-like: delta0 active, lower clamp reached
        load_cfg(3 << 16, -(1 << 15), 3 << 16, 1 << 22, 3 << 16, 2 << 16);
        x_pending_q.push_back(32'h8000_0000);
        x_pending_q.push_back(clip32(-(1 << 15) - (64 << 16)));
        x_pending_q.push_back(clip32(-(1 << 15) - 1));
        queue_random(90);
        // crossed limits
        load_cfg(-(5 << 16), 2 << 16, -(2 << 16), 32'sh7FFF_FFFF, 1 << 16, 32'h7FFF_FFFF);
        x_pending_q.push_back(clip32(2 << 16));
        x_pending_q.push_back(clip32((2 << 16) - 1));
        queue_random(90);
        // exponent zero, negative coefficient
        load_cfg(1 << 16, -(4 << 16), 4 << 16, -64'sh8000_0000, 0, 0);
        queue_random(100);
        // largest exponent, extreme constants, saturation both ways
        load_cfg(-64'sh8000_0000, -64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                 1048576, 32'h7FFF_FFFF);
        queue_random(100);
        load_cfg(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -64'sh8000_0000, -64'sh8000_0000,
                 1048576, 1);
        queue_random(100);

        for (int ph = 0; ph < 9; ph++)
        begin
            longint x0, x1;
            x0 = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            x1 = x0 + $urandom_range(0, 6 << 16);
            load_cfg($signed($urandom_range(0, 14 << 16)) - (2 << 16), x0, x1,
                     ($urandom_range(0, 3) == 0) ? longint'($signed($urandom))
                         : longint'($signed($urandom_range(0, 1 << 24)) - (1 << 23)),
                     $urandom_range(0, 1048576),
                     ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 32'h7FFF_FFFF));
            no_idle = (ph % 4 == 3);
            queue_random(130);
        end
        wait_idle();
        finished = 1'b1;
        if (mismatches == 0 && delta_exp_q.size() == 0)
            $display("** density_effect_correction_core: PASSED **");
        else
            $display("** density_effect_correction_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20_000_000;
        if (!finished)
        begin
            $display("** density_effect_correction_core: FAILED **");
            $finish;
        end
    end

endmodule
